[rtl/dhst_pkg.sv]
// Shared types and constants of the double hashing symbol table.
package dhst_pkg;

   localparam int KEY_W      = 32;
   localparam int SIZE_W     = 11;
   localparam int CHAR_W     = 8;
   localparam int VTYPE_W    = 2;
   localparam int STATUS_W   = 3;
   localparam int SLOT_W     = 10;
   localparam int PROBE_W    = 11;
   localparam int MIN_SIZE   = 5;
   localparam int STEP_OFS   = 3;
   localparam int RESET_SIZE = 1021;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED   = 3'd0,
      ST_DUPLICATE  = 3'd1,
      ST_FULL       = 3'd2,
      ST_FOUND      = 3'd3,
      ST_UNDECLARED = 3'd4,
      ST_TOO_LONG   = 3'd5
   } status_type;

   typedef enum logic {
      MODE_DECLARE = 1'b0,
      MODE_USE     = 1'b1
   } mode_type;

endpackage

[rtl/double_hash_symbol_table.sv]
// Double hashing symbol table: Horner key, iterative modulo, probe walk, insert.
// Characters that do not end a name are taken one per cycle, back to back, while idle.
// A last character runs the shared remainder unit twice (home slot, then step), then walks the probes,
// comparing stored characters where lengths match, and on insert writes the name's characters.
// One name is in work at a time; the result waits in its register until taken.
// Reset is synchronous; it starts a clearing pass over every slot of the table.
module double_hash_symbol_table
   import dhst_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024,
   parameter int NAME_CHARS  = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // character[7:0], var_type[9:8], zero
   input  logic                  req_tuser,   // mode
   input  logic                  req_tlast,   // last_char
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // status, slot, home_slot, found_type,
                                              // probe_count, zero
   input  logic                  csr_we,
   input  logic [SIZE_W-1:0]     csr_wdata
);

   localparam int SW    = $clog2(TABLE_DEPTH);
   localparam int MW    = SW + 1;
   localparam int CW    = $clog2(NAME_CHARS);
   localparam int LEN_W = $clog2(NAME_CHARS + 1);
   localparam int META_W = 1 + VTYPE_W + LEN_W;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DIV, S_PRB_WAIT, S_PRB_CHK, S_CMP_WAIT, S_CMP_CHK, S_WRITE,
      S_DONE
   } state_type;

   state_type              state_ff;
   logic [SIZE_W-1:0]      size_ff;
   logic [KEY_W-1:0]       key_ff;
   logic [LEN_W-1:0]       len_ff;
   logic                   ovf_ff;
   logic                   mode_ff;
   logic [VTYPE_W-1:0]     vtype_ff;
   logic [CHAR_W-1:0]      buf_ff [NAME_CHARS];
   logic [MW-1:0]          m_ff;
   logic                   phase_ff;
   logic [4:0]             bitcnt_ff;
   logic [SW-1:0]          rem_ff;
   logic [SW-1:0]          home_ff;
   logic [SW-1:0]          step_ff;
   logic [SW-1:0]          idx_ff;
   logic [MW-1:0]          probe_ff;
   logic [LEN_W-1:0]       cidx_ff;
   logic [SW-1:0]          clr_ff;
   logic [STATUS_W-1:0]    status_ff;
   logic [SW-1:0]          slot_ff;
   logic [VTYPE_W-1:0]     ftype_ff;

   logic [META_W-1:0]      meta_mem [TABLE_DEPTH];
   logic [CHAR_W-1:0]      name_mem [TABLE_DEPTH * (2 ** CW)];
   logic [META_W-1:0]      meta_rd_ff;
   logic [CHAR_W-1:0]      name_rd_ff;

   logic                   meta_we;
   logic [SW-1:0]          meta_wa;
   logic [META_W-1:0]      meta_wd;
   logic                   name_we;

   logic                   req_acc;
   logic [CHAR_W-1:0]      req_char;
   logic [KEY_W-1:0]       key_in;
   logic [MW-1:0]          m_in;
   logic [MW-1:0]          divisor;
   logic [MW-1:0]          trial;
   logic [SW-1:0]          rem_in;
   logic [MW-1:0]          idx_sum;
   logic [SW-1:0]          idx_in;
   logic                   meta_used;
   logic [VTYPE_W-1:0]     meta_type;
   logic [LEN_W-1:0]       meta_len;
   logic                   cidx_last;
   logic                   walk_end;
   logic [CHAR_W-1:0]      buf_rd;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign req_char   = req_tdata[CHAR_W-1:0];
   assign key_in     = (key_ff << 5) - key_ff + KEY_W'(req_char);

   always_comb begin
      if (size_ff < SIZE_W'(MIN_SIZE)) begin
         m_in = MW'(MIN_SIZE);
      end else if (32'(size_ff) > TABLE_DEPTH) begin
         m_in = MW'(TABLE_DEPTH);
      end else begin
         m_in = MW'(size_ff);
      end
   end

   assign divisor = phase_ff ? (m_ff - MW'(STEP_OFS)) : m_ff;
   assign trial   = {rem_ff, key_ff[bitcnt_ff]};
   assign rem_in  = (trial >= divisor) ? SW'(trial - divisor) : SW'(trial);
   assign idx_sum = {1'b0, idx_ff} + {1'b0, step_ff};
   assign idx_in  = (idx_sum >= m_ff) ? SW'(idx_sum - m_ff) : SW'(idx_sum);

   assign meta_used = meta_rd_ff[META_W-1];
   assign meta_type = meta_rd_ff[META_W-2 -: VTYPE_W];
   assign meta_len  = meta_rd_ff[LEN_W-1:0];
   assign cidx_last = (cidx_ff == len_ff - LEN_W'(1));
   assign walk_end  = (probe_ff == m_ff);
   assign buf_rd    = buf_ff[cidx_ff[CW-1:0]];

   assign meta_we = (state_ff == S_CLEAR) ||
                    (state_ff == S_PRB_CHK && !meta_used && mode_ff == MODE_DECLARE);
   assign meta_wa = (state_ff == S_CLEAR) ? clr_ff : idx_ff;
   assign meta_wd = (state_ff == S_CLEAR) ? '0 : {1'b1, vtype_ff, len_ff};
   assign name_we = (state_ff == S_WRITE);

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_wa] <= meta_wd;
      end
      meta_rd_ff <= meta_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (name_we) begin
         name_mem[{idx_ff, cidx_ff[CW-1:0]}] <= buf_rd;
      end
      name_rd_ff <= name_mem[{idx_ff, cidx_ff[CW-1:0]}];
   end

   always_ff @(posedge clock) begin
      if (req_acc && len_ff < LEN_W'(NAME_CHARS)) begin
         buf_ff[len_ff[CW-1:0]] <= req_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_W'(RESET_SIZE);
      end else if (csr_we) begin
         size_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         key_ff    <= '0;
         len_ff    <= '0;
         ovf_ff    <= 1'b0;
         probe_ff  <= '0;
         status_ff <= ST_INSERTED;
         slot_ff   <= '0;
         home_ff   <= '0;
         ftype_ff  <= '0;
      end else begin
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + SW'(1);
               if (clr_ff == SW'(TABLE_DEPTH - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_acc) begin
                  key_ff <= key_in;
                  if (len_ff < LEN_W'(NAME_CHARS)) begin
                     len_ff <= len_ff + LEN_W'(1);
                  end else begin
                     ovf_ff <= 1'b1;
                  end
                  if (req_tlast) begin
                     mode_ff   <= req_tuser;
                     vtype_ff  <= req_tdata[CHAR_W +: VTYPE_W];
                     m_ff      <= m_in;
                     probe_ff  <= '0;
                     slot_ff   <= '0;
                     home_ff   <= '0;
                     ftype_ff  <= '0;
                     phase_ff  <= 1'b0;
                     bitcnt_ff <= 5'd31;
                     rem_ff    <= '0;
                     if (ovf_ff || len_ff == LEN_W'(NAME_CHARS)) begin
                        status_ff <= ST_TOO_LONG;
                        state_ff  <= S_DONE;
                     end else begin
                        state_ff <= S_DIV;
                     end
                  end
               end
            end
            S_DIV: begin
               bitcnt_ff <= bitcnt_ff - 5'd1;
               rem_ff    <= rem_in;
               if (bitcnt_ff == 5'd0) begin
                  rem_ff <= '0;
                  if (!phase_ff) begin
                     home_ff   <= rem_in;
                     phase_ff  <= 1'b1;
                     bitcnt_ff <= 5'd31;
                  end else begin
                     step_ff  <= rem_in + SW'(1);
                     idx_ff   <= home_ff;
                     state_ff <= S_PRB_WAIT;
                  end
               end
            end
            S_PRB_WAIT: begin
               probe_ff <= probe_ff + MW'(1);
               state_ff <= S_PRB_CHK;
            end
            S_PRB_CHK: begin
               cidx_ff <= '0;
               if (!meta_used) begin
                  if (mode_ff == MODE_DECLARE) begin
                     status_ff <= ST_INSERTED;
                     slot_ff   <= idx_ff;
                     state_ff  <= S_WRITE;
                  end else begin
                     status_ff <= ST_UNDECLARED;
                     state_ff  <= S_DONE;
                  end
               end else if (meta_len == len_ff) begin
                  state_ff <= S_CMP_WAIT;
               end else if (walk_end) begin
                  status_ff <= (mode_ff == MODE_DECLARE) ? ST_FULL : ST_UNDECLARED;
                  state_ff  <= S_DONE;
               end else begin
                  idx_ff   <= idx_in;
                  state_ff <= S_PRB_WAIT;
               end
            end
            S_CMP_WAIT: begin
               state_ff <= S_CMP_CHK;
            end
            S_CMP_CHK: begin
               if (name_rd_ff == buf_rd) begin
                  if (cidx_last) begin
                     status_ff <= (mode_ff == MODE_DECLARE) ? ST_DUPLICATE : ST_FOUND;
                     slot_ff   <= idx_ff;
                     ftype_ff  <= meta_type;
                     state_ff  <= S_DONE;
                  end else begin
                     cidx_ff  <= cidx_ff + LEN_W'(1);
                     state_ff <= S_CMP_WAIT;
                  end
               end else if (walk_end) begin
                  status_ff <= (mode_ff == MODE_DECLARE) ? ST_FULL : ST_UNDECLARED;
                  state_ff  <= S_DONE;
               end else begin
                  idx_ff   <= idx_in;
                  state_ff <= S_PRB_WAIT;
               end
            end
            S_WRITE: begin
               cidx_ff <= cidx_ff + LEN_W'(1);
               if (cidx_last) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (rsp_tready) begin
                  key_ff   <= '0;
                  len_ff   <= '0;
                  ovf_ff   <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = (state_ff == S_DONE);
   assign rsp_tdata  = {4'b0, PROBE_W'(probe_ff), ftype_ff, SLOT_W'(home_ff),
                        SLOT_W'(slot_ff), status_ff};

`ifndef ASSERT_OFF
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input taken while a result waits");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> ({1'b0, rem_ff} < divisor))
      else $error("remainder out of range");

   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PRB_CHK) |-> (probe_ff != '0 && probe_ff <= m_ff))
      else $error("probe count out of range");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PRB_WAIT) |-> ({1'b0, idx_ff} < m_ff))
      else $error("probe index beyond table size");
`endif

endmodule

[tb/dhst_checker.sv]
// Checker for the double hashing symbol table: tracks table state, predicts and compares.
`timescale 1ns / 100ps
module dhst_checker
   import dhst_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [SIZE_W-1:0]     csr_wdata,
   output int                    errors,
   output int                    pending
);
   localparam int DEPTH = 1024;
   localparam int NCH   = 32;

   typedef struct packed {
      logic [PROBE_W-1:0]  probes;
      logic [1:0]          ftype;
      logic [SLOT_W-1:0]   home;
      logic [SLOT_W-1:0]   slot;
      status_type          status;
   } lookup_t;

   bit                used_q[DEPTH];
   logic [1:0]        type_q[DEPTH];
   logic [7:0]        chars_q[DEPTH][NCH];
   int                len_q[DEPTH];
   logic [7:0]        name_buf[NCH];
   int                name_len;
   logic [31:0]       name_key;
   bit                name_long;
   logic [SIZE_W-1:0] size_q;
   lookup_t           expected_q[$];

   function automatic bit name_equal(int s);
      if (len_q[s] != name_len) return 0;
      for (int k = 0; k < name_len; k++)
         if (chars_q[s][k] != name_buf[k]) return 0;
      return 1;
   endfunction

   task automatic finish_name(mode_type mode, logic [1:0] vtype);
      lookup_t r;
      int m, stp, idx;
      r = '0;
      if (name_long) begin
         r.status = ST_TOO_LONG;
      end else begin
         m = size_q < MIN_SIZE ? MIN_SIZE : (size_q > DEPTH ? DEPTH : size_q);
         stp = 1 + int'(name_key % (m - STEP_OFS));
         r.home = SLOT_W'(name_key % m);
         r.status = mode == MODE_DECLARE ? ST_FULL : ST_UNDECLARED;
         for (int i = 0; i < m; i++) begin
            idx = int'((longint'(r.home) + longint'(i) * stp) % m);
            r.probes = PROBE_W'(i + 1);
            if (!used_q[idx]) begin
               if (mode == MODE_DECLARE) begin
                  used_q[idx] = 1;
                  type_q[idx] = vtype;
                  len_q[idx] = name_len;
                  for (int k = 0; k < name_len; k++) chars_q[idx][k] = name_buf[k];
                  r.status = ST_INSERTED;
                  r.slot = SLOT_W'(idx);
               end else begin
                  r.status = ST_UNDECLARED;
               end
               break;
            end
            if (name_equal(idx)) begin
               r.status = mode == MODE_DECLARE ? ST_DUPLICATE : ST_FOUND;
               r.slot = SLOT_W'(idx);
               r.ftype = type_q[idx];
               break;
            end
         end
      end
      expected_q.push_back(r);
      name_len = 0;
      name_key = '0;
      name_long = 0;
   endtask

   assign pending = expected_q.size();

   always @(posedge clock) begin
      lookup_t got, exp_r;
      if (reset) begin
         for (int s = 0; s < DEPTH; s++) used_q[s] = 0;
         name_len = 0;
         name_key = '0;
         name_long = 0;
         size_q = SIZE_W'(RESET_SIZE);
         expected_q.delete();
         errors = 0;
      end else begin
         if (csr_we) size_q = csr_wdata;
         if (req_tvalid && req_tready) begin
            name_key = name_key * 32'd31 + 32'(req_tdata[7:0]);
            if (name_len < NCH) begin
               name_buf[name_len] = req_tdata[7:0];
               name_len++;
            end else begin
               name_long = 1;
            end
            if (req_tlast) finish_name(mode_type'(req_tuser), req_tdata[9:8]);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(lookup_t)-1:0];
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result %h", $time, got);
               errors++;
            end else begin
               exp_r = expected_q.pop_front();
               if (got !== exp_r) begin
                  $display("%0t: mismatch expected st=%0d slot=%0d home=%0d ty=%0d pr=%0d",
                     $time, exp_r.status, exp_r.slot, exp_r.home, exp_r.ftype, exp_r.probes);
                  $display("%0t:          actual   st=%0d slot=%0d home=%0d ty=%0d pr=%0d",
                     $time, got.status, got.slot, got.home, got.ftype, got.probes);
                  errors++;
               end
            end
         end
      end
   end
endmodule

[tb/tb.sv]
// Testbench top for the double hashing symbol table: stimulus and verdict.
`timescale 1ns / 100ps
module tb;
   import dhst_pkg::*;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 0;
   logic                  req_tlast = 0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 0;
   logic [SIZE_W-1:0]     csr_wdata = '0;
   int                    errors, pending;
   int                    idle_cycles = 0;
   bit                    calm = 0;
   bit                    hold_rsp = 0;
   int                    hold_len = 0;
   logic [7:0]            pool[8][40];
   int                    pool_len[8];

   localparam int WATCHDOG = 400000;

   always #5 clock = ~clock;

   double_hash_symbol_table i_dut (.*);
   dhst_checker i_chk (.*);

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_len > 0) begin
         hold_len <= hold_len - 1;
         rsp_tready <= 0;
      end else if (hold_rsp) begin
         hold_len <= 3000;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= calm || $urandom_range(99) >= 30;
      end
   end

   task automatic send_char(logic [7:0] ch, bit last, mode_type mode, logic [1:0] vt);
      while (!calm && $urandom_range(99) < 30) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {6'd0, vt, ch};
      req_tlast <= last;
      req_tuser <= mode;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_name(logic [7:0] nm[], mode_type mode, logic [1:0] vt);
      for (int k = 0; k < nm.size(); k++)
         send_char(nm[k], k == nm.size() - 1, mode, vt);
      req_tvalid <= 0;
      @(posedge clock);
   endtask

   task automatic random_name(int n, mode_type mode);
      logic [7:0] nm[];
      nm = new[n];
      foreach (nm[k]) nm[k] = 8'($urandom_range(255));
      send_name(nm, mode, 2'($urandom_range(3)));
   endtask

   task automatic pool_name(mode_type mode);
      logic [7:0] nm[];
      int p;
      p = $urandom_range(7);
      nm = new[pool_len[p]];
      foreach (nm[k]) nm[k] = pool[p][k];
      send_name(nm, mode, 2'($urandom_range(3)));
   endtask

   task automatic drain;
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic set_size(int v);
      drain();
      csr_we <= 1;
      csr_wdata <= SIZE_W'(v);
      @(posedge clock);
      csr_we <= 0;
   endtask

   initial begin
      logic [7:0] nm[];
      int sizes[6] = '{1021, 5, 1024, 2047, 0, 97};
      repeat (10) @(posedge clock);
      reset <= 0;
      for (int p = 0; p < 8; p++) begin
         pool_len[p] = p == 7 ? 33 + $urandom_range(6) : $urandom_range(1, 32);
         for (int k = 0; k < 40; k++) pool[p][k] = 8'($urandom_range(255));
      end
      nm = new[1];
      nm[0] = 8'hff; send_name(nm, MODE_DECLARE, 2);
      send_name(nm, MODE_DECLARE, 1);
      send_name(nm, MODE_USE, 0);
      nm[0] = 8'h00; send_name(nm, MODE_USE, 0);
      send_name(nm, MODE_DECLARE, 3);
      send_name(nm, MODE_USE, 0);
      nm = new[32];
      foreach (nm[k]) nm[k] = 8'(8'hff - k);
      send_name(nm, MODE_DECLARE, 1);
      send_name(nm, MODE_USE, 2);
      random_name(33, MODE_DECLARE);
      random_name(40, MODE_USE);
      set_size(5);
      for (int k = 0; k < 7; k++) random_name($urandom_range(1, 3), MODE_DECLARE);
      random_name(2, MODE_USE);
      for (int ph = 0; ph < 6; ph++) begin
         set_size(sizes[ph]);
         if (ph == 1) calm = 1;
         if (ph == 2) begin
            fork
               begin hold_rsp = 1; repeat (2) @(posedge clock); hold_rsp = 0; end
               for (int k = 0; k < 6; k++) random_name(1, MODE_DECLARE);
            join
         end
         for (int k = 0; k < 13; k++) begin
            case ($urandom_range(9))
               0:       random_name($urandom_range(33, 36), mode_type'($urandom_range(1)));
               1, 2, 3: pool_name(mode_type'($urandom_range(1)));
               default: random_name($urandom_range(1, 6), mode_type'($urandom_range(1)));
            endcase
         end
         calm = 0;
      end
      drain();
      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
